// ===== rtl/core/wtd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtd_pkg
// Types and constants shared by the whitespace tokenizer and its channels.
// ----------------------------------------------------------------------------
package wtd_pkg;

    localparam int FIELD_W = 16;

    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_END    = 2'd1;
    localparam logic [1:0] EV_NUMBER = 2'd2;
    localparam logic [1:0] EV_STRING = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] REG_START_EN  = 2'd0;
    localparam logic [1:0] REG_END_EN    = 2'd1;
    localparam logic [1:0] REG_NUMBER_EN = 2'd2;
    localparam logic [1:0] REG_TEXT_EN   = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // largest value that can still take another digit: (2^64-1)/10, (2^64-1)%10
    localparam logic [63:0] VALUE_LIMIT = 64'h1999_9999_9999_9999;
    localparam logic [3:0]  LIMIT_DIGIT = 4'd5;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [63:0]        number_value;
        logic [FIELD_W-1:0] token_offset;
        logic [FIELD_W-1:0] token_length;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic       data;
    } cfg_req_t;

    typedef struct packed {
        logic [1:0] num;
        out_item_t  first;
        out_item_t  second;
    } wtd_push_t;

endpackage

// ===== rtl/core/wtd_in_if.sv =====
// ----------------------------------------------------------------------------
// wtd_in_if
// Input byte channel: valid/ready with one line byte or end-of-line request.
// ----------------------------------------------------------------------------
interface wtd_in_if;
    import wtd_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wtd_out_if.sv =====
// ----------------------------------------------------------------------------
// wtd_out_if
// Result channel: valid/ready with one tokenizer event.
// ----------------------------------------------------------------------------
interface wtd_out_if;
    import wtd_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wtd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wtd_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface wtd_cfg_if;
    import wtd_pkg::*;

    logic     valid;
    logic     ready;
    cfg_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wtd_result_queue.sv =====
// ----------------------------------------------------------------------------
// wtd_result_queue
// Four-entry result queue; takes up to two events per cycle, sends one while result.ready is high.
// ----------------------------------------------------------------------------
module wtd_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  wtd_pkg::wtd_push_t push,
    output logic               room,
    wtd_out_if.source          result
);
    import wtd_pkg::*;

    out_item_t  mem_reg [4];
    logic [1:0] head_reg;
    logic [1:0] head_next;
    logic [1:0] tail_reg;
    logic [1:0] tail_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign room           = (count_reg <= 3'd2);
    assign result.valid   = (count_reg != 3'd0);
    assign result.payload = mem_reg[head_reg];
    assign pop            = result.valid && result.ready;

    always_comb
    begin
        head_next  = head_reg + {1'b0, pop};
        tail_next  = tail_reg + push.num;
        count_next = count_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[tail_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end
endmodule

// ===== rtl/core/whitespace_tokenizer_decimal.sv =====
// Events enter the result queue when their request is accepted and are offered
// from its head. Throughput: one request per cycle while the queue has room; a
// request with two events is buffered by the four-entry result queue.
// Reset: all enables clear, no line open, result queue empty.
// ----------------------------------------------------------------------------
// whitespace_tokenizer_decimal
// Splits a byte stream into whitespace-separated tokens, parsing digit tokens.
// ----------------------------------------------------------------------------
module whitespace_tokenizer_decimal #(
    parameter int POSITION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wtd_in_if.sink    item,
    wtd_cfg_if.sink   cfg,
    wtd_out_if.source result
);
    import wtd_pkg::*;

    logic                     start_en_reg;
    logic                     end_en_reg;
    logic                     number_en_reg;
    logic                     text_en_reg;

    logic                     line_open_reg;
    logic                     line_open_next;
    logic                     inside_reg;
    logic                     inside_next;
    logic                     digits_reg;
    logic                     digits_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic [63:0]              value_reg;
    logic [63:0]              value_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] begin_reg;
    logic [POSITION_BITS-1:0] begin_next;

    logic                     accept;
    logic                     room;
    logic                     is_end;
    logic                     is_sep;
    logic                     is_digit;
    logic [3:0]               digit;
    logic                     cur_inside;
    logic                     cur_digits;
    logic                     cur_ovf;
    logic [63:0]              cur_value;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] cur_begin;
    logic [POSITION_BITS-1:0] tok_len;
    logic [63:0]              value_x10;
    logic                     will_ovf;

    logic                     start_v;
    logic                     tok_v;
    logic                     end_v;
    logic                     closing;
    out_item_t                start_ev;
    out_item_t                tok_ev;
    out_item_t                end_ev;
    wtd_push_t                push;

    assign accept     = item.valid && item.ready;
    assign item.ready = room;
    assign cfg.ready  = 1'b1;

    assign is_end   = (item.payload.command == CMD_END);
    assign is_sep   = (item.payload.byte_value == CH_SPACE) ||
                      (item.payload.byte_value == CH_TAB) ||
                      (item.payload.byte_value == CH_NL) ||
                      (item.payload.byte_value == CH_NUL);
    assign is_digit = (item.payload.byte_value >= CH_ZERO) &&
                      (item.payload.byte_value <= CH_NINE);
    assign digit    = 4'(item.payload.byte_value - CH_ZERO);

    // a closed line behaves as a freshly opened one
    assign cur_inside = line_open_reg && inside_reg;
    assign cur_digits = !line_open_reg || digits_reg;
    assign cur_ovf    = line_open_reg && ovf_reg;
    assign cur_value  = line_open_reg ? value_reg : '0;
    assign cur_pos    = line_open_reg ? pos_reg : '0;
    assign cur_begin  = line_open_reg ? begin_reg : '0;
    assign tok_len    = cur_pos - cur_begin;

    assign value_x10 = {cur_value[60:0], 3'b000} + {cur_value[62:0], 1'b0};
    assign will_ovf  = (cur_value > VALUE_LIMIT) ||
                       ((cur_value == VALUE_LIMIT) && (digit > LIMIT_DIGIT));

    always_comb
    begin
        closing = accept && (is_end || is_sep) && cur_inside;
        start_v = accept && !line_open_reg && start_en_reg;
        end_v   = accept && is_end && end_en_reg;
        tok_v   = closing && (cur_digits ? (number_en_reg && (!cur_ovf || text_en_reg))
                                         : text_en_reg);

        start_ev              = '0;
        start_ev.event_kind   = EV_START;
        end_ev                = '0;
        end_ev.event_kind     = EV_END;
        tok_ev                = '0;
        tok_ev.event_kind     = (cur_digits && !cur_ovf) ? EV_NUMBER : EV_STRING;
        tok_ev.number_value   = (cur_digits && !cur_ovf) ? cur_value : '0;
        tok_ev.token_offset   = FIELD_W'(cur_begin);
        tok_ev.token_length   = FIELD_W'(tok_len);

        push          = '0;
        push.num      = 2'({1'b0, start_v} + {1'b0, tok_v} + {1'b0, end_v});
        push.first    = start_v ? start_ev : (tok_v ? tok_ev : end_ev);
        push.second   = (start_v && tok_v) ? tok_ev : end_ev;
        if (push.num == 2'd1)
        begin
            push.first.last_of_run = 1'b1;
        end
        push.second.last_of_run = 1'b1;
    end

    always_comb
    begin
        line_open_next = line_open_reg;
        inside_next    = inside_reg;
        digits_next    = digits_reg;
        ovf_next       = ovf_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        begin_next     = begin_reg;
        if (accept)
        begin
            if (is_end)
            begin
                line_open_next = 1'b0;
                inside_next    = 1'b0;
                digits_next    = 1'b1;
                ovf_next       = 1'b0;
                value_next     = '0;
                pos_next       = '0;
                begin_next     = '0;
            end
            else
            begin
                line_open_next = 1'b1;
                pos_next       = cur_pos + 1'b1;
                if (is_sep)
                begin
                    inside_next = 1'b0;
                    digits_next = 1'b1;
                    ovf_next    = 1'b0;
                    value_next  = '0;
                    begin_next  = cur_begin;
                end
                else
                begin
                    inside_next = 1'b1;
                    begin_next  = cur_inside ? cur_begin : cur_pos;
                    digits_next = cur_inside ? cur_digits : 1'b1;
                    ovf_next    = cur_inside ? cur_ovf : 1'b0;
                    value_next  = cur_inside ? cur_value : '0;
                    if (is_digit)
                    begin
                        if (!(cur_inside && cur_ovf))
                        begin
                            if (cur_inside && will_ovf)
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (cur_inside)
                            begin
                                value_next = value_x10 + 64'(digit);
                            end
                            else
                            begin
                                value_next = 64'(digit);
                            end
                        end
                    end
                    else
                    begin
                        digits_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_en_reg  <= 1'b0;
            end_en_reg    <= 1'b0;
            number_en_reg <= 1'b0;
            text_en_reg   <= 1'b0;
            line_open_reg <= 1'b0;
            inside_reg    <= 1'b0;
            digits_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
            value_reg     <= '0;
            pos_reg       <= '0;
            begin_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.payload.index)
                    REG_START_EN:  start_en_reg  <= cfg.payload.data;
                    REG_END_EN:    end_en_reg    <= cfg.payload.data;
                    REG_NUMBER_EN: number_en_reg <= cfg.payload.data;
                    REG_TEXT_EN:   text_en_reg   <= cfg.payload.data;
                endcase
            end
            line_open_reg <= line_open_next;
            inside_reg    <= inside_next;
            digits_reg    <= digits_next;
            ovf_reg       <= ovf_next;
            value_reg     <= value_next;
            pos_reg       <= pos_next;
            begin_reg     <= begin_next;
        end
    end

    wtd_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );
endmodule
